// ===== hw/rtl/srb_pkg.sv =====
// ----------------------------------------------------------------------------
// srb_pkg
// Shared types and field widths for the sequence reorder buffer.
// ----------------------------------------------------------------------------
`default_nettype none

package srb_pkg;

   localparam int SEQ_W = 8;
   localparam int PAY_W = 32;

   typedef logic [SEQ_W-1:0] seq_type;
   typedef logic [PAY_W-1:0] pay_type;

   // contents of one window slot
   typedef struct packed {
      logic    valid;
      pay_type payload;
   } slot_type;

endpackage

`default_nettype wire

// ===== hw/rtl/srb_if.sv =====
// ----------------------------------------------------------------------------
// srb_req_if / srb_rsp_if
// Valid/ready channels for arriving messages and released messages.
// ----------------------------------------------------------------------------
`default_nettype none

interface srb_req_if;
   import srb_pkg::*;

   logic    valid;
   logic    ready;
   seq_type seq_number;
   pay_type payload;

   modport source (output valid, output seq_number, output payload, input ready);
   modport sink (input valid, input seq_number, input payload, output ready);
endinterface

interface srb_rsp_if;
   import srb_pkg::*;

   logic    valid;
   logic    ready;
   seq_type out_seq;
   pay_type out_payload;
   logic    last_of_run;
   logic    out_of_window;

   modport source (output valid, output out_seq, output out_payload,
                   output last_of_run, output out_of_window, input ready);
   modport sink (input valid, input out_seq, input out_payload,
                 input last_of_run, input out_of_window, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/srb_cell.sv =====
// ----------------------------------------------------------------------------
// srb_cell
// One window slot; loads an arriving message or takes its upper neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module srb_cell (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              write_en,
   input  wire srb_pkg::pay_type  write_payload,
   input  wire logic              shift_en,
   input  wire srb_pkg::slot_type upper,
   output      srb_pkg::slot_type slot
);
   import srb_pkg::*;

   logic    valid_ff;
   logic    valid_in;
   pay_type payload_ff;
   pay_type payload_in;

   always_comb begin
      valid_in   = valid_ff;
      payload_in = payload_ff;
      if (shift_en) begin
         valid_in   = upper.valid;
         payload_in = upper.payload;
      end else if (write_en) begin
         valid_in   = 1'b1;
         payload_in = write_payload;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      payload_ff <= payload_in;
   end

   assign slot = {valid_ff, payload_ff};

endmodule

`default_nettype wire

// ===== hw/rtl/sequence_reorder_buffer_core.sv =====
// ----------------------------------------------------------------------------
// sequence_reorder_buffer_core
// Reorder window of DEPTH slots; releases messages in sequence order.
// ----------------------------------------------------------------------------
//  channel   dir  fields
//  req_chan  in   seq_number, payload
//  rsp_chan  out  out_seq, out_payload, last_of_run, out_of_window
//
//  slot 0 holds next_expected; each release shifts the chain down one slot
//  an item is taken, then each release it causes shifts the chain in turn; the next
//  item is taken once slot 0 is empty and the output register is free
//  an out-of-window item gives one flagged result and leaves the window as is
//  synchronous reset empties all slots and zeroes next_expected
//  a stalled rsp_chan holds the output register and pauses the chain
// ----------------------------------------------------------------------------
`default_nettype none

module sequence_reorder_buffer_core #(
   parameter int DEPTH    = 16,
   parameter int SEQ_BITS = 8
) (
   input wire logic  clock,
   input wire logic  reset,
   srb_req_if.sink   req_chan,
   srb_rsp_if.source rsp_chan
);
   import srb_pkg::*;

   localparam int CW = SEQ_BITS + SEQ_W;

   slot_type            slots [DEPTH];
   logic [DEPTH-1:0]    write_en;
   logic [SEQ_BITS-1:0] next_exp_ff;
   logic [SEQ_BITS-1:0] next_exp_in;
   logic [CW-1:0]       seq_wide;
   logic [CW-1:0]       seq_kept;
   logic [CW-1:0]       exp_wide;
   logic [SEQ_BITS-1:0] seq_in;
   logic [SEQ_BITS-1:0] offset;
   logic                in_window;
   logic                out_free;
   logic                drain;
   logic                accept;

   logic    rsp_valid_ff, rsp_valid_in;
   seq_type rsp_seq_ff, rsp_seq_in;
   pay_type rsp_payload_ff, rsp_payload_in;
   logic    rsp_last_ff, rsp_last_in;
   logic    rsp_oow_ff, rsp_oow_in;

   assign seq_wide  = CW'(req_chan.seq_number);
   assign seq_in    = seq_wide[SEQ_BITS-1:0];
   assign seq_kept  = CW'(seq_in);
   assign exp_wide  = CW'(next_exp_ff);
   assign offset    = seq_in - next_exp_ff;
   assign in_window = CW'(offset) < CW'(DEPTH);

   assign out_free       = !rsp_valid_ff || rsp_chan.ready;
   assign drain          = slots[0].valid && out_free;
   assign req_chan.ready = !slots[0].valid && out_free;
   assign accept         = req_chan.valid && req_chan.ready;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      slot_type upper;

      if (i == DEPTH - 1) begin : g_top
         assign upper = '0;
      end else begin : g_mid
         assign upper = slots[i+1];
      end

      assign write_en[i] = accept && in_window && (CW'(offset) == CW'(i));

      srb_cell u_cell (
         .clock         (clock),
         .reset         (reset),
         .write_en      (write_en[i]),
         .write_payload (req_chan.payload),
         .shift_en      (drain),
         .upper         (upper),
         .slot          (slots[i])
      );
   end

   always_comb begin
      next_exp_in    = next_exp_ff;
      rsp_valid_in   = rsp_valid_ff;
      rsp_seq_in     = rsp_seq_ff;
      rsp_payload_in = rsp_payload_ff;
      rsp_last_in    = rsp_last_ff;
      rsp_oow_in     = rsp_oow_ff;
      if (drain) begin
         next_exp_in    = next_exp_ff + 1'b1;
         rsp_valid_in   = 1'b1;
         rsp_seq_in     = exp_wide[SEQ_W-1:0];
         rsp_payload_in = slots[0].payload;
         rsp_last_in    = !slots[1].valid;
         rsp_oow_in     = 1'b0;
      end else if (accept && !in_window) begin
         rsp_valid_in   = 1'b1;
         rsp_seq_in     = seq_kept[SEQ_W-1:0];
         rsp_payload_in = '0;
         rsp_last_in    = 1'b0;
         rsp_oow_in     = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         next_exp_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         next_exp_ff  <= next_exp_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_seq_ff     <= rsp_seq_in;
      rsp_payload_ff <= rsp_payload_in;
      rsp_last_ff    <= rsp_last_in;
      rsp_oow_ff     <= rsp_oow_in;
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_seq       = rsp_seq_ff;
   assign rsp_chan.out_payload   = rsp_payload_ff;
   assign rsp_chan.last_of_run   = rsp_last_ff;
   assign rsp_chan.out_of_window = rsp_oow_ff;

endmodule

`default_nettype wire
